>>> hdl/kmuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmuf_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd1;

    // Reset geometry.
    localparam logic [CFG_DATA_W-1:0] GRID_RESET = 7'd64;

    // Fixed widths of the coordinate fields and of the working coordinates.
    localparam int WALL_W  = 6;
    localparam int COORD_W = 9;

    // Distance from an open cell to the far border, in cells.
    localparam logic [COORD_W-1:0] BORDER_SPAN = 9'd2;

    // Result codes.
    typedef enum logic [1:0] {
        OUTCOME_REJECT = 2'd0,
        OUTCOME_SAME   = 2'd1,
        OUTCOME_JOINED = 2'd2
    } outcome_t;

    typedef struct packed {
        outcome_t outcome;
        logic     carved;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/kmuf_parent_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kmuf_parent_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 13
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/kmuf_cell_check.sv
`timescale 1ns / 1ps
`default_nettype none

module kmuf_cell_check #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int CW       = 12
) (
    input  wire logic [kmuf_pkg::WALL_W-1:0]     wall_row,
    input  wire logic [kmuf_pkg::WALL_W-1:0]     wall_col,
    input  wire logic                            test_vertical,
    input  wire logic [kmuf_pkg::CFG_DATA_W-1:0] grid_rows,
    input  wire logic [kmuf_pkg::CFG_DATA_W-1:0] grid_cols,
    output logic                                 both_open,
    output logic      [CW-1:0]                   cell_a,
    output logic      [CW-1:0]                   cell_b
);

    import kmuf_pkg::*;

    logic [COORD_W-1:0] lim_rows;
    logic [COORD_W-1:0] lim_cols;
    logic [COORD_W-1:0] row_ext;
    logic [COORD_W-1:0] col_ext;
    logic [COORD_W-1:0] r1;
    logic [COORD_W-1:0] c1;
    logic [COORD_W-1:0] r2;
    logic [COORD_W-1:0] c2;
    logic               underflow;

    // An open coordinate is odd and leaves room for the far border.
    function automatic logic coord_ok(input logic [COORD_W-1:0] v,
                                      input logic [COORD_W-1:0] lim);
        return v[0] && ((v + BORDER_SPAN) <= lim);
    endfunction

    // Geometry in use, clamped to the table size.
    always_comb
    begin
        lim_rows = {2'b00, grid_rows};
        if (lim_rows > COORD_W'(MAX_ROWS))
        begin
            lim_rows = COORD_W'(MAX_ROWS);
        end
        lim_cols = {2'b00, grid_cols};
        if (lim_cols > COORD_W'(MAX_COLS))
        begin
            lim_cols = COORD_W'(MAX_COLS);
        end
    end

    // The two neighbors of the wall; the second one sits before the wall.
    always_comb
    begin
        row_ext = {3'b000, wall_row};
        col_ext = {3'b000, wall_col};
        if (test_vertical)
        begin
            r1        = row_ext + 9'd1;
            c1        = col_ext;
            r2        = row_ext - 9'd1;
            c2        = col_ext;
            underflow = (wall_row == '0);
        end
        else
        begin
            r1        = row_ext;
            c1        = col_ext + 9'd1;
            r2        = row_ext;
            c2        = col_ext - 9'd1;
            underflow = (wall_col == '0);
        end
    end

    assign both_open = !underflow
                       && coord_ok(r1, lim_rows) && coord_ok(c1, lim_cols)
                       && coord_ok(r2, lim_rows) && coord_ok(c2, lim_cols);

    // Row-major cell index; only meaningful when both cells are open.
    assign cell_a = CW'(32'(r1) * MAX_COLS + 32'(c1));
    assign cell_b = CW'(32'(r2) * MAX_COLS + 32'(c2));

endmodule

`default_nettype wire

>>> hdl/kmuf_find_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kmuf_find_ctrl #(
    parameter int DEPTH = 4096,
    parameter int CW    = 12
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           both_open,
    input  wire logic [CW-1:0]  cell_a,
    input  wire logic [CW-1:0]  cell_b,
    output logic                rd_en,
    output logic      [CW-1:0]  rd_addr,
    input  wire logic [CW:0]    rd_data,
    output logic                wr_en,
    output logic      [CW-1:0]  wr_addr,
    output logic      [CW:0]    wr_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output kmuf_pkg::result_t   result
);

    import kmuf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_EMIT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   clear_idx_reg;
    logic [CW-1:0]   cur_reg;
    logic [CW-1:0]   cell_b_reg;
    logic [CW-1:0]   root_a_reg;
    result_t         pend_reg;
    logic            out_valid_reg;
    result_t         out_res_reg;

    logic            accept;
    logic            has_up;
    logic [CW-1:0]   link;
    logic            out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign has_up   = rd_data[CW];
    assign link     = rd_data[CW-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    // Parent table read: the entry for the next step of the current walk.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en   = accept && both_open;
                rd_addr = cell_a;
            end
            ST_WALK_A:
            begin
                rd_en   = 1'b1;
                rd_addr = has_up ? link : cell_b_reg;
            end
            ST_WALK_B:
            begin
                rd_en   = has_up;
                rd_addr = link;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = cur_reg;
            end
        endcase
    end

    // Parent table write: the clearing pass, or linking the first root.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = root_a_reg;
        wr_data = {1'b1, cur_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clear_idx_reg;
                wr_data = '0;
            end
            ST_WALK_B:
            begin
                wr_en   = !has_up && (root_a_reg != cur_reg);
                wr_addr = root_a_reg;
                wr_data = {1'b1, cur_reg};
            end
            default:
            begin
                wr_en   = 1'b0;
            end
        endcase
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            cell_b_reg    <= '0;
            root_a_reg    <= '0;
            pend_reg      <= '{outcome: OUTCOME_REJECT, carved: 1'b0};
            out_res_reg   <= '{outcome: OUTCOME_REJECT, carved: 1'b0};
        end
        else
        begin
            // A waiting result fills the output register; otherwise the
            // downstream transfer frees it.
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clear_idx_reg <= clear_idx_reg + 1'b1;
                    if (clear_idx_reg == CW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg    <= cell_a;
                        cell_b_reg <= cell_b;
                        if (both_open)
                        begin
                            state_reg <= ST_WALK_A;
                        end
                        else
                        begin
                            pend_reg  <= '{outcome: OUTCOME_REJECT, carved: 1'b0};
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_WALK_A:
                begin
                    if (has_up)
                    begin
                        cur_reg <= link;
                    end
                    else
                    begin
                        root_a_reg <= cur_reg;
                        cur_reg    <= cell_b_reg;
                        state_reg  <= ST_WALK_B;
                    end
                end
                ST_WALK_B:
                begin
                    if (has_up)
                    begin
                        cur_reg <= link;
                    end
                    else
                    begin
                        if (root_a_reg == cur_reg)
                        begin
                            pend_reg <= '{outcome: OUTCOME_SAME, carved: 1'b0};
                        end
                        else
                        begin
                            pend_reg <= '{outcome: OUTCOME_JOINED, carved: 1'b1};
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_res_reg   <= pend_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_res_reg;

endmodule

`default_nettype wire

>>> hdl/kruskal_maze_union_find_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  wall_row, wall_col, test_vertical
// result    out        out_valid/out_stall  outcome, carved
// config    in         cfg_write            cfg_index, cfg_data
//
// After reset the parent table is cleared, all MAX_ROWS * MAX_COLS entries, one
// entry a cycle, with in_stall high; configuration writes are taken throughout.
// A rejected item passes from idle through the emit state to the output register;
// an item that is tested first walks both root chains, one parent table read per
// cycle. One item is in flight at a time. in_stall stays high while an item is in
// flight or its result waits for a free output register.

module kruskal_maze_union_find_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [kmuf_pkg::WALL_W-1:0]     wall_row,
    input  wire logic [kmuf_pkg::WALL_W-1:0]     wall_col,
    input  wire logic                            test_vertical,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [1:0]                      outcome,
    output logic                                 carved,
    input  wire logic                            cfg_write,
    input  wire logic [kmuf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kmuf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import kmuf_pkg::*;

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int CW         = $clog2(CELL_COUNT);

    logic [CFG_DATA_W-1:0] grid_rows_reg;
    logic [CFG_DATA_W-1:0] grid_cols_reg;

    logic          both_open;
    logic [CW-1:0] cell_a;
    logic [CW-1:0] cell_b;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic [CW:0]   rd_data;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [CW:0]   wr_data;
    result_t       result;

    // Geometry registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Neighbor cells of the candidate wall.
    kmuf_cell_check #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_cell_check (
        .wall_row      (wall_row),
        .wall_col      (wall_col),
        .test_vertical (test_vertical),
        .grid_rows     (grid_rows_reg),
        .grid_cols     (grid_cols_reg),
        .both_open     (both_open),
        .cell_a        (cell_a),
        .cell_b        (cell_b)
    );

    // Root walks, linking and the output register.
    kmuf_find_ctrl #(
        .DEPTH (CELL_COUNT),
        .CW    (CW)
    ) u_find_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .both_open (both_open),
        .cell_a    (cell_a),
        .cell_b    (cell_b),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // Parent table: has-parent bit over the parent cell index.
    kmuf_parent_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (CW),
        .DW    (CW + 1)
    ) u_parent_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign outcome = result.outcome;
    assign carved  = result.carved;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import kmuf_pkg::*;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 64;
    localparam int CELL_COUNT    = MAX_ROWS * MAX_COLS;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 12;
    localparam int WALLS_PER_PHASE = 100;

    // Indexes that map to no register; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [WALL_W-1:0]      wall_row;
    logic [WALL_W-1:0]      wall_col;
    logic                   test_vertical;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             outcome;
    logic                   carved;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow of the geometry registers and of the union-find forest.
    int      shadow_rows;
    int      shadow_cols;
    bit      forest_linked [CELL_COUNT];
    int      forest_up     [CELL_COUNT];

    // Verdicts predicted for accepted walls, oldest first.
    result_t verdict_q[$];
    result_t oldest;
    int      error_count;
    int      cycle_count;
    bit      calm;

    kruskal_maze_union_find_core #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .wall_row     (wall_row),
        .wall_col     (wall_col),
        .test_vertical(test_vertical),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .outcome      (outcome),
        .carved       (carved),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle lengths: mostly short, sometimes medium, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A cell is open when it is odd in both coordinates and inside the border.
    function automatic bit cell_open(input int r, input int c);
        int nr;
        int nc;
        nr = (shadow_rows > MAX_ROWS) ? MAX_ROWS : shadow_rows;
        nc = (shadow_cols > MAX_COLS) ? MAX_COLS : shadow_cols;
        if (r < 1 || c < 1 || r > nr - 2 || c > nc - 2)
            return 1'b0;
        return (r % 2 == 1) && (c % 2 == 1);
    endfunction

    // Follow parent links up to the set representative.
    function automatic int root_of(input int node);
        int steps;
        steps = 0;
        while (forest_linked[node] && steps < CELL_COUNT)
        begin
            node = forest_up[node] % CELL_COUNT;
            steps++;
        end
        return node;
    endfunction

    // Decide the fate of one wall and update the forest on a join.
    function automatic result_t judge_wall(input int row, input int col, input bit vert);
        int      r1;
        int      c1;
        int      r2;
        int      c2;
        int      root_a;
        int      root_b;
        result_t verdict;
        verdict.outcome = OUTCOME_REJECT;
        verdict.carved  = 1'b0;
        if (vert)
        begin
            r1 = row + 1; c1 = col;
            r2 = row - 1; c2 = col;
        end
        else
        begin
            r1 = row; c1 = col + 1;
            r2 = row; c2 = col - 1;
        end
        if (cell_open(r1, c1) && cell_open(r2, c2))
        begin
            root_a = root_of(r1 * MAX_COLS + c1);
            root_b = root_of(r2 * MAX_COLS + c2);
            if (root_a == root_b)
                verdict.outcome = OUTCOME_SAME;
            else
            begin
                forest_linked[root_a] = 1'b1;
                forest_up[root_a]     = root_b;
                verdict.outcome       = OUTCOME_JOINED;
                verdict.carved        = 1'b1;
            end
        end
        return verdict;
    endfunction

    // Offer one wall, wait for the transfer, then record its verdict.
    task automatic send_wall(input int row, input int col, input bit vert);
        int      gap;
        result_t verdict;
        gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        wall_row      <= WALL_W'(row);
        wall_col      <= WALL_W'(col);
        test_vertical <= vert;
        do
            @(posedge clk);
        while (in_stall);
        verdict = judge_wall(row, col, vert);
        verdict_q.insert(verdict_q.size(), verdict);
    endtask

    // Stop sending and wait until every verdict has come back.
    task automatic hold_until_empty(input int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // One register write; the shadow follows only the known indexes.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_GRID_ROWS)
            shadow_rows = value & 'h7F;
        else if (idx == REG_GRID_COLS)
            shadow_cols = value & 'h7F;
    endtask

    task automatic set_geometry(input int rows, input int cols);
        hold_until_empty(SETTLE_CYCLES);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_GRID_ROWS, rows);
            write_reg(REG_GRID_COLS, cols);
        end
        else
        begin
            write_reg(REG_GRID_COLS, cols);
            write_reg(REG_GRID_ROWS, rows);
        end
    endtask

    // Mostly walls between two open cells of the current grid, some noise.
    task automatic make_wall(output int row, output int col, output bit vert);
        int eff_r;
        int eff_c;
        int n_r;
        int n_c;
        eff_r = (shadow_rows > MAX_ROWS) ? MAX_ROWS : shadow_rows;
        eff_c = (shadow_cols > MAX_COLS) ? MAX_COLS : shadow_cols;
        n_r   = (eff_r >= 3) ? (eff_r - 1) / 2 : 0;
        n_c   = (eff_c >= 3) ? (eff_c - 1) / 2 : 0;
        vert  = $urandom_range(0, 1);
        row   = $urandom_range(0, 63);
        col   = $urandom_range(0, 63);
        if ($urandom_range(0, 99) >= 15)
        begin
            if (vert && n_r >= 2 && n_c >= 1)
            begin
                row = 2 * $urandom_range(0, n_r - 2) + 2;
                col = 2 * $urandom_range(0, n_c - 1) + 1;
            end
            else if (!vert && n_r >= 1 && n_c >= 2)
            begin
                row = 2 * $urandom_range(0, n_r - 1) + 1;
                col = 2 * $urandom_range(0, n_c - 2) + 2;
            end
        end
    endtask

    // Walls at the field extremes and at the grid border, reset geometry.
    task automatic test_borders();
        send_wall(0, 0, 1'b0);
        send_wall(0, 0, 1'b1);
        send_wall(63, 63, 1'b1);
        send_wall(63, 63, 1'b0);
        send_wall(62, 61, 1'b1);
        send_wall(61, 62, 1'b0);
        send_wall(2, 2, 1'b1);
        send_wall(1, 1, 1'b0);
    endtask

    // Joins, a repeated wall and a wall that closes a loop.
    task automatic test_unions();
        send_wall(1, 2, 1'b0);
        send_wall(1, 2, 1'b0);
        send_wall(2, 1, 1'b1);
        send_wall(2, 3, 1'b1);
        send_wall(3, 2, 1'b0);
        send_wall(60, 61, 1'b1);
        send_wall(61, 60, 1'b0);
    endtask

    // Clamped, degenerate and tiny grids, and writes to unused indexes.
    task automatic test_geometry_regs();
        set_geometry(127, 127);
        send_wall(60, 61, 1'b1);
        set_geometry(0, 64);
        send_wall(1, 2, 1'b0);
        set_geometry(2, 64);
        send_wall(2, 1, 1'b1);
        set_geometry(64, 1);
        send_wall(1, 2, 1'b0);
        set_geometry(3, 5);
        send_wall(1, 2, 1'b0);
        send_wall(1, 4, 1'b0);
        hold_until_empty(SETTLE_CYCLES);
        write_reg(REG_SPARE_2, 0);
        write_reg(REG_SPARE_3, 127);
        send_wall(1, 2, 1'b0);
    endtask

    // Random walls over a series of geometries with random idling.
    task automatic test_random_walls();
        int rows_plan [PHASES] = '{64, 5, 9, 127, 64, 3, 64, 13, 0, 0, 33, 64};
        int cols_plan [PHASES] = '{64, 5, 17, 64, 127, 64, 3, 13, 0, 0, 9, 64};
        int p;
        int k;
        int row;
        int col;
        bit vert;
        for (p = 0; p < PHASES; p++)
        begin
            if (rows_plan[p] == 0)
                set_geometry($urandom_range(3, 64), $urandom_range(3, 64));
            else
                set_geometry(rows_plan[p], cols_plan[p]);
            if (p == 3)
                write_reg(REG_SPARE_2, $urandom_range(0, 127));
            calm = (p % 4 == 2);
            for (k = 0; k < WALLS_PER_PHASE; k++)
            begin
                make_wall(row, col, vert);
                send_wall(row, col, vert);
                if (!calm && $urandom_range(0, 99) < 3)
                    hold_until_empty(1);
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: random stall runs, none while calm.
    int stall_run;
    initial
    begin
        out_stall <= 1'b0;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                stall_run = pick_gap() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare every result transfer with the oldest verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got outcome %0d carved %0d",
                         $time, outcome, carved);
            end
            else
            begin
                oldest = verdict_q.pop_front();
                if (outcome !== oldest.outcome)
                begin
                    error_count++;
                    $display("%0t: outcome mismatch, expected %0d, got %0d",
                             $time, oldest.outcome, outcome);
                end
                if (carved !== oldest.carved)
                begin
                    error_count++;
                    $display("%0t: carved mismatch, expected %0d, got %0d",
                             $time, oldest.carved, carved);
                end
            end
        end
    end

    // Watchdog.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        calm          = 1'b0;
        shadow_rows   = GRID_RESET;
        shadow_cols   = GRID_RESET;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        wall_row      <= '0;
        wall_col      <= '0;
        test_vertical <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_GRID_ROWS;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_borders();
        test_unions();
        test_geometry_regs();
        test_random_walls();

        hold_until_empty(20);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
